@@ rtl/ratt_pkg.sv @@
// ----------------------------------------------------------------------------
// ratt_pkg
// Shared types and codes for the range address translation table.
// ----------------------------------------------------------------------------
`default_nettype none

package ratt_pkg;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_XLAT   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EXISTS   = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_ZEROLEN  = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_CMP,
        S_DECIDE,
        S_MV_CHK,
        S_MV_WR,
        S_INS,
        S_RM_CHK,
        S_RM_WR,
        S_XLAT,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        RA_IDX,
        RA_IDX_M1,
        RA_IDX_P1
    } rd_sel_t;

    typedef struct packed {
        logic    ld_req;
        logic    idx_clr;
        logic    idx_inc;
        logic    idx_dec;
        logic    idx_ld_count;
        logic    idx_ld_pos;
        logic    pos_ld;
        logic    found_val;
        logic    ent_ld;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    we;
        logic    wr_new;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    st_ld;
        status_t st_code;
        logic    xlat_ld;
        logic    out_ld;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic len_zero;
        logic at_end;
        logic end_above;
        logic start_le;
        logic full;
        logic found;
        logic idx_eq_pos;
        logic idx_p1_eq_count;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

@@ rtl/ratt_if.sv @@
// ----------------------------------------------------------------------------
// ratt_req_if / ratt_rsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface ratt_req_if #(parameter int VADDR_BITS = 48);
    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic [VADDR_BITS-1:0] vaddr;
    logic [VADDR_BITS-1:0] length;
    logic [63:0]           target_iova;

    modport source (output valid, req_type, vaddr, length, target_iova, input ready);
    modport sink   (input valid, req_type, vaddr, length, target_iova, output ready);
endinterface

interface ratt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        hit;
    logic [63:0] translated_iova;

    modport source (output valid, status, hit, translated_iova, input ready);
    modport sink   (input valid, status, hit, translated_iova, output ready);
endinterface

`default_nettype wire

@@ rtl/ratt_ram.sv @@
// ----------------------------------------------------------------------------
// ratt_ram
// Generic simple dual-port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ratt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/ratt_ctrl.sv @@
// ----------------------------------------------------------------------------
// ratt_ctrl
// Sequencer for scan, sorted insert, remove and translate.
// ----------------------------------------------------------------------------
`default_nettype none

module ratt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ratt_pkg::sts_t sts,
    output ratt_pkg::cmd_t     cmd
);
    import ratt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if ((sts.req == REQ_ADD && sts.len_zero) || sts.req == REQ_NONE)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:   state_next = sts.at_end ? S_DECIDE : S_CMP;
            S_CMP:    state_next = sts.end_above ? S_DECIDE : S_SCAN;
            S_DECIDE:
            begin
                priority if (sts.req == REQ_ADD)
                begin
                    state_next = (sts.found || sts.full) ? S_RESP : S_MV_CHK;
                end
                else if (sts.req == REQ_REMOVE)
                begin
                    state_next = sts.found ? S_RM_CHK : S_RESP;
                end
                else
                begin
                    state_next = sts.found ? S_XLAT : S_RESP;
                end
            end
            S_MV_CHK: state_next = sts.idx_eq_pos ? S_INS : S_MV_WR;
            S_MV_WR:  state_next = S_MV_CHK;
            S_INS:    state_next = S_RESP;
            S_RM_CHK: state_next = sts.idx_p1_eq_count ? S_RESP : S_RM_WR;
            S_RM_WR:  state_next = S_RM_CHK;
            S_XLAT:   state_next = S_RESP;
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.rd_sel = RA_IDX;
        cmd.st_code = ST_OK;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.ld_req = in_valid;
                cmd.idx_clr = in_valid;
            end
            S_START:
            begin
                cmd.st_ld = 1'b1;
                cmd.st_code = (sts.req == REQ_ADD && sts.len_zero) ? ST_ZEROLEN : ST_OK;
            end
            S_SCAN:
            begin
                if (sts.at_end)
                begin
                    cmd.pos_ld = 1'b1;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            S_CMP:
            begin
                if (sts.end_above)
                begin
                    cmd.pos_ld = 1'b1;
                    cmd.found_val = sts.start_le;
                    cmd.ent_ld = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_DECIDE:
            begin
                priority if (sts.req == REQ_ADD)
                begin
                    if (sts.found)
                    begin
                        cmd.st_ld = 1'b1;
                        cmd.st_code = ST_EXISTS;
                    end
                    else if (sts.full)
                    begin
                        cmd.st_ld = 1'b1;
                        cmd.st_code = ST_FULL;
                    end
                    else
                    begin
                        cmd.idx_ld_count = 1'b1;
                    end
                end
                else if (sts.req == REQ_REMOVE)
                begin
                    if (sts.found)
                    begin
                        cmd.idx_ld_pos = 1'b1;
                    end
                    else
                    begin
                        cmd.st_ld = 1'b1;
                        cmd.st_code = ST_NOTFOUND;
                    end
                end
                else
                begin
                    if (!sts.found)
                    begin
                        cmd.st_ld = 1'b1;
                        cmd.st_code = ST_NOTFOUND;
                    end
                end
            end
            S_MV_CHK:
            begin
                if (!sts.idx_eq_pos)
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_sel = RA_IDX_M1;
                end
            end
            S_MV_WR:
            begin
                cmd.we = 1'b1;
                cmd.idx_dec = 1'b1;
            end
            S_INS:
            begin
                cmd.we = 1'b1;
                cmd.wr_new = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            S_RM_CHK:
            begin
                if (sts.idx_p1_eq_count)
                begin
                    cmd.cnt_dec = 1'b1;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_sel = RA_IDX_P1;
                end
            end
            S_RM_WR:
            begin
                cmd.we = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            S_XLAT:   cmd.xlat_ld = 1'b1;
            S_RESP:   cmd.out_ld = sts.out_free;
            default:  cmd = '0;
        endcase
    end

    // a response is only produced from the response state
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld |-> state_reg == S_RESP)
        else $error("response loaded outside response state");

    // ram writes only happen while moving or inserting entries
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.we |-> (state_reg == S_MV_WR || state_reg == S_INS || state_reg == S_RM_WR))
        else $error("unexpected table write");

    // after an accepted request the sequencer leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> state_reg == S_START)
        else $error("request accepted but not started");

endmodule

`default_nettype wire

@@ rtl/ratt_dp.sv @@
// ----------------------------------------------------------------------------
// ratt_dp
// Datapath: request registers, table ram, counters and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ratt_dp #(
    parameter int ENTRIES    = 64,
    parameter int VADDR_BITS = 48
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [1:0]            req_type,
    input  wire logic [VADDR_BITS-1:0] vaddr,
    input  wire logic [VADDR_BITS-1:0] length,
    input  wire logic [63:0]           target_iova,
    input  wire ratt_pkg::cmd_t        cmd,
    output ratt_pkg::sts_t             sts,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [2:0]                 out_status,
    output logic                       out_hit,
    output logic [63:0]                out_xlat
);
    import ratt_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int DW = 2 * VADDR_BITS + 64;

    req_t                  req_reg;
    logic [VADDR_BITS-1:0] va_reg;
    logic [VADDR_BITS-1:0] len_reg;
    logic [63:0]           tgt_reg;
    logic [CW-1:0]         idx_reg;
    logic [CW-1:0]         pos_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  found_reg;
    logic [VADDR_BITS-1:0] off_reg;
    logic [63:0]           etgt_reg;
    status_t               status_reg;
    logic                  hit_reg;
    logic [63:0]           xlat_reg;
    logic                  out_valid_reg;
    logic [2:0]            out_status_reg;
    logic                  out_hit_reg;
    logic [63:0]           out_xlat_reg;

    logic [DW-1:0]         rdata;
    logic [DW-1:0]         wdata;
    logic [CW-1:0]         raddr;
    logic [VADDR_BITS-1:0] r_start;
    logic [VADDR_BITS-1:0] r_len;
    logic [63:0]           r_tgt;
    logic [VADDR_BITS-1:0] diff;

    assign r_start = rdata[VADDR_BITS-1:0];
    assign r_len   = rdata[2*VADDR_BITS-1:VADDR_BITS];
    assign r_tgt   = rdata[DW-1:2*VADDR_BITS];
    assign diff    = va_reg - r_start;

    always_comb
    begin
        unique case (cmd.rd_sel)
            RA_IDX_M1: raddr = idx_reg - CW'(1);
            RA_IDX_P1: raddr = idx_reg + CW'(1);
            default:   raddr = idx_reg;
        endcase
    end

    assign wdata = cmd.wr_new ? {tgt_reg, len_reg, va_reg} : rdata;

    ratt_ram #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.we),
        .waddr (idx_reg[AW-1:0]),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr[AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.ld_req)
        begin
            req_reg <= req_t'(req_type);
            va_reg  <= vaddr;
            len_reg <= length;
            tgt_reg <= target_iova;
            hit_reg <= 1'b0;
            xlat_reg <= '0;
        end
        if (cmd.pos_ld)
        begin
            pos_reg <= idx_reg;
        end
        if (cmd.ent_ld)
        begin
            off_reg  <= diff;
            etgt_reg <= r_tgt;
        end
        if (cmd.st_ld)
        begin
            status_reg <= cmd.st_code;
        end
        if (cmd.xlat_ld)
        begin
            status_reg <= ST_OK;
            hit_reg    <= 1'b1;
            xlat_reg   <= etgt_reg + 64'(off_reg);
        end
        if (cmd.cnt_inc || cmd.cnt_dec)
        begin
            status_reg <= ST_OK;
        end
        if (cmd.out_ld)
        begin
            out_status_reg <= status_reg;
            out_hit_reg    <= hit_reg;
            out_xlat_reg   <= xlat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_ld_count)
            begin
                idx_reg <= cnt_reg;
            end
            else if (cmd.idx_ld_pos)
            begin
                idx_reg <= pos_reg;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            else if (cmd.idx_dec)
            begin
                idx_reg <= idx_reg - CW'(1);
            end
            if (cmd.pos_ld)
            begin
                found_reg <= cmd.found_val;
            end
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.req             = req_reg;
        sts.len_zero        = (len_reg == '0);
        sts.at_end          = (idx_reg == cnt_reg);
        sts.start_le        = (r_start <= va_reg);
        sts.end_above       = (r_start > va_reg) || (diff < r_len);
        sts.full            = (cnt_reg == CW'(ENTRIES));
        sts.found           = found_reg;
        sts.idx_eq_pos      = (idx_reg == pos_reg);
        sts.idx_p1_eq_count = ((idx_reg + CW'(1)) == cnt_reg);
        sts.out_free        = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_hit    = out_hit_reg;
    assign out_xlat   = out_xlat_reg;

    // the entry count never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(ENTRIES))
        else $error("entry count overflow");

    // writes land at or below the current count
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.we |-> idx_reg <= cnt_reg && idx_reg < CW'(ENTRIES))
        else $error("table write out of range");

    // the count moves by one only on an increment or decrement command
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> ($past(cmd.cnt_inc) || $past(cmd.cnt_dec)))
        else $error("count changed without command");

endmodule

`default_nettype wire

@@ rtl/range_address_translation_table_unit.sv @@
// ----------------------------------------------------------------------------
// range_address_translation_table_unit
// Sorted table of address ranges with add, remove and translate requests.
//
//   channel  dir  fields
//   req      in   req_type, vaddr, length, target_iova
//   rsp      out  status, hit, translated_iova
//
// one request at a time; a lookup scans the table entry by entry through
// the single read port of the table ram, reading and then comparing each
// entry; a zero length add or unused code responds without a scan. an
// insert then moves the entries above the insert point up by one, and a
// remove moves those above the removed entry down by one. reset empties
// the table at once. a finished response waits in an output register; the
// next request may be accepted meanwhile but cannot respond until that
// response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module range_address_translation_table_unit #(
    parameter int ENTRIES    = 64,
    parameter int VADDR_BITS = 48
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ratt_req_if.sink  req,
    ratt_rsp_if.source rsp
);
    import ratt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ratt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ratt_dp #(
        .ENTRIES    (ENTRIES),
        .VADDR_BITS (VADDR_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_type    (req.req_type),
        .vaddr       (req.vaddr),
        .length      (req.length),
        .target_iova (req.target_iova),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_status  (rsp.status),
        .out_hit     (rsp.hit),
        .out_xlat    (rsp.translated_iova)
    );

endmodule

`default_nettype wire
